// ===== rtl/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// Inverse-CDF scatter sampler package
// Shared widths, command codes, controller states and the command and status
// records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package isc_pkg;

  // Default table sizes.
  localparam int NUM_GROUPS_DEF = 16;
  localparam int MAX_ANGLES_DEF = 8;

  // Field widths of one item.
  localparam int CMD_W    = 3;
  localparam int GRP_W    = 4;
  localparam int SLOT_W   = 3;
  localparam int CDF_W    = 17;
  localparam int COS_W    = 17;
  localparam int CNTIN_W  = 4;
  localparam int FRAC_W   = 16;

  // Stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  // Bit offsets inside the input tdata word.
  localparam int IN_FROM_LSB = 0;
  localparam int IN_TO_LSB   = IN_FROM_LSB + GRP_W;
  localparam int IN_SLOT_LSB = IN_TO_LSB + GRP_W;
  localparam int IN_CDF_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_COS_LSB  = IN_CDF_LSB + CDF_W;
  localparam int IN_CNT_LSB  = IN_COS_LSB + COS_W;
  localparam int IN_FRAC_LSB = IN_CNT_LSB + CNTIN_W;
  localparam int IN_ISO_BIT  = IN_FRAC_LSB + FRAC_W;
  localparam int IN_USED_W   = IN_ISO_BIT + 1;

  // Bit offsets inside the output tdata word.
  localparam int OUT_GRP_LSB = 0;
  localparam int OUT_COS_LSB = OUT_GRP_LSB + GRP_W;
  localparam int OUT_USED_W  = OUT_COS_LSB + COS_W;

  // Q1.15 limits of a cosine.
  localparam logic signed [COS_W-1:0] COS_POS_ONE = 17'sd32768;
  localparam logic signed [COS_W-1:0] COS_NEG_ONE = -17'sd32768;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_GROUP     = 3'd0,
    CMD_WR_ANGLE     = 3'd1,
    CMD_WR_COUNT     = 3'd2,
    CMD_SAMPLE_GROUP = 3'd3,
    CMD_SAMPLE_ANGLE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_WALK,
    ST_EMIT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the accepted item, perform table writes
    logic walk_en;   // step through table entries
    logic capture;   // latch the finished result
    logic out_load;  // move the latched result into the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_done;
  } dp_sts_t;

endpackage

// ===== rtl/isc_datapath.sv =====
// ----------------------------------------------------------------------------
// Inverse-CDF scatter sampler datapath
// Table memories, entry walk counter, compare, result and output registers.
// ----------------------------------------------------------------------------
module isc_datapath import isc_pkg::*; #(
  parameter int NUM_GROUPS = NUM_GROUPS_DEF,
  parameter int MAX_ANGLES = MAX_ANGLES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  cmd_e                     in_cmd_i,
  input  logic [GRP_W-1:0]         from_i,
  input  logic [GRP_W-1:0]         to_i,
  input  logic [SLOT_W-1:0]        slot_i,
  input  logic [CDF_W-1:0]         cdf_i,
  input  logic signed [COS_W-1:0]  cos_i,
  input  logic [CNTIN_W-1:0]       cnt_i,
  input  logic [FRAC_W-1:0]        frac_i,
  input  logic                     iso_i,
  output logic                     res_kind_o,
  output logic [GRP_W-1:0]         exit_group_o,
  output logic signed [COS_W-1:0]  cosine_o
);

  localparam int GW     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int AW     = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
  localparam int CW     = $clog2(MAX_ANGLES + 1);
  localparam int LIM    = (NUM_GROUPS > MAX_ANGLES) ? NUM_GROUPS : MAX_ANGLES;
  localparam int IW     = $clog2(LIM + 1);
  localparam int PAIR_W = 2 * GRP_W;
  localparam int PAIRS  = 1 << PAIR_W;
  localparam int G_AW   = GRP_W + GW;
  localparam int A_AW   = PAIR_W + AW;

  function automatic logic signed [COS_W-1:0] clamp_cos(input logic signed [COS_W-1:0] c);
    if (c > COS_POS_ONE) begin
      return COS_POS_ONE;
    end else if (c < COS_NEG_ONE) begin
      return COS_NEG_ONE;
    end
    return c;
  endfunction

  // Memories.
  logic [CDF_W-1:0]        g_mem   [1 << G_AW];
  logic signed [COS_W-1:0] a_cos_mem [1 << A_AW];
  logic [CDF_W-1:0]        a_cdf_mem [1 << A_AW];
  logic [CW-1:0]           c_mem   [PAIRS];
  logic [PAIRS-1:0]        c_valid_q;

  logic from_ok, to_ok, slot_ok;
  logic [PAIR_W-1:0] in_pair;
  logic [CW-1:0]     cnt_sat;

  assign from_ok = 32'(from_i) < NUM_GROUPS;
  assign to_ok   = 32'(to_i) < NUM_GROUPS;
  assign slot_ok = 32'(slot_i) < MAX_ANGLES;
  assign in_pair = {from_i, to_i};
  assign cnt_sat = CW'((32'(cnt_i) > MAX_ANGLES) ? MAX_ANGLES : 32'(cnt_i));

  logic wr_group, wr_angle, wr_count;

  always_comb begin
    wr_group = 1'b0;
    wr_angle = 1'b0;
    wr_count = 1'b0;
    if (cmd_i.load) begin
      unique case (in_cmd_i)
        CMD_WR_GROUP: wr_group = from_ok && to_ok;
        CMD_WR_ANGLE: wr_angle = from_ok && to_ok && slot_ok;
        CMD_WR_COUNT: wr_count = from_ok && to_ok;
        default:      ;
      endcase
    end
  end

  // Item registers.
  logic [GRP_W-1:0]  from_q, to_q;
  logic [FRAC_W-1:0] r_q;
  logic              iso_q, kind_q, grp_ok_q, pair_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      from_q    <= from_i;
      to_q      <= to_i;
      r_q       <= frac_i;
      iso_q     <= iso_i;
      kind_q    <= (in_cmd_i == CMD_SAMPLE_ANGLE);
      grp_ok_q  <= from_ok;
      pair_ok_q <= from_ok && to_ok;
    end
  end

  // Walk counter.
  logic [IW-1:0] idx_q, idx_d, cmp_idx_q, limit;
  logic          dvalid_q, dvalid_d, issue;

  logic [CDF_W-1:0]        g_rd_q, a_cdf_q;
  logic signed [COS_W-1:0] a_cos_q;
  logic [CW-1:0]           cnt_rd_q, cnt_eff;
  logic                    cval_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_group) begin
      g_mem[{from_i, GW'(to_i)}] <= cdf_i;
    end
    g_rd_q <= g_mem[{from_q, idx_q[GW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (wr_angle) begin
      a_cos_mem[{in_pair, AW'(slot_i)}] <= cos_i;
    end
    a_cos_q <= a_cos_mem[{from_q, to_q, idx_q[AW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (wr_angle) begin
      a_cdf_mem[{in_pair, AW'(slot_i)}] <= cdf_i;
    end
    a_cdf_q <= a_cdf_mem[{from_q, to_q, idx_q[AW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (wr_count) begin
      c_mem[in_pair] <= cnt_sat;
    end
    cnt_rd_q <= c_mem[{from_q, to_q}];
  end

  // A pair whose count was never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= '0;
      cval_rd_q <= 1'b0;
    end else begin
      if (wr_count) begin
        c_valid_q[in_pair] <= 1'b1;
      end
      cval_rd_q <= c_valid_q[{from_q, to_q}];
    end
  end

  logic iso_sel, hit;

  assign cnt_eff = cval_rd_q ? cnt_rd_q : '0;
  assign iso_sel = iso_q || !pair_ok_q || (cnt_eff == '0);

  always_comb begin
    if (kind_q) begin
      limit = iso_sel ? '0 : IW'(cnt_eff);
    end else begin
      limit = grp_ok_q ? IW'(NUM_GROUPS) : '0;
    end
  end

  assign issue = cmd_i.walk_en && (idx_q < limit);
  assign hit   = dvalid_q && (kind_q ? ({1'b0, r_q} < a_cdf_q) : ({1'b0, r_q} < g_rd_q));
  assign sts_o.walk_done = cmd_i.walk_en && (hit || (!dvalid_q && !issue));

  always_comb begin
    idx_d    = idx_q;
    dvalid_d = 1'b0;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (issue) begin
      idx_d    = idx_q + 1'b1;
      dvalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      dvalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      dvalid_q <= dvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
  end

  // Result and output registers.
  logic                    res_kind_q, out_kind_q;
  logic [GRP_W-1:0]        res_grp_q, out_grp_q;
  logic signed [COS_W-1:0] res_cos_q, out_cos_q, iso_cos;

  assign iso_cos = $signed({1'b0, r_q}) - COS_POS_ONE;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_kind_q <= kind_q;
      if (kind_q) begin
        res_grp_q <= '0;
        if (iso_sel) begin
          res_cos_q <= clamp_cos(iso_cos);
        end else if (hit) begin
          res_cos_q <= clamp_cos(a_cos_q);
        end else begin
          res_cos_q <= '0;
        end
      end else begin
        res_cos_q <= '0;
        res_grp_q <= hit ? GRP_W'(cmp_idx_q) : '0;
      end
    end
    if (cmd_i.out_load) begin
      out_kind_q <= res_kind_q;
      out_grp_q  <= res_grp_q;
      out_cos_q  <= res_cos_q;
    end
  end

  assign res_kind_o   = out_kind_q;
  assign exit_group_o = out_grp_q;
  assign cosine_o     = out_cos_q;

endmodule

// ===== rtl/isc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Inverse-CDF scatter sampler controller
// Sequences one item at a time and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module isc_ctrl import isc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  output logic    s_ready_o,
  input  cmd_e    in_cmd_i,
  input  logic    m_ready_i,
  output logic    m_valid_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   accept, out_free;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign out_free  = !m_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == CMD_SAMPLE_GROUP) begin
            state_d = ST_WALK;
          end else if (in_cmd_i == CMD_SAMPLE_ANGLE) begin
            state_d = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        // The pair's angle count is read during this cycle.
        state_d = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_en = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

// ===== rtl/inverse_cdf_scatter_sampler.sv =====
// ----------------------------------------------------------------------------
// Inverse-CDF scatter sampler
// Group and angle tables loaded by write items, sampled by inverse CDF lookup.
// ----------------------------------------------------------------------------
// A write item is performed at acceptance. A sample item walks its table one
// entry per cycle through a registered memory read until the first hit or the
// last entry; an angle item first reads the pair's count and skips the walk
// when isotropic. The result passes the result and output registers.
// Throughput: one item at a time; the next is accepted once the result moves
// into the output register. Reset clears the controller and the valid bits.
// ----------------------------------------------------------------------------
module inverse_cdf_scatter_sampler import isc_pkg::*; #(
  parameter int NUM_GROUPS = NUM_GROUPS_DEF,
  parameter int MAX_ANGLES = MAX_ANGLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input item stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: from_group[3:0], to_group[7:4], angle_index[10:8],
  // cdf_value[27:11], angle_cosine[44:28], angle_count[48:45],
  // random_fraction[64:49], isotropic[65], zero padding[71:66].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser from bit 0: cmd[2:0].
  input  logic [CMD_W-1:0]      s_axis_tuser,
  // Result item stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: exit_group[3:0], cosine[20:4], zero padding[23:21].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser from bit 0: result_kind[0].
  output logic                  m_axis_tuser
);

  // Commands and status between the controller and the datapath.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  cmd_e    in_cmd;

  // The command code arrives on tuser; unused codes decode to no action.
  assign in_cmd = cmd_e'(s_axis_tuser);

  logic                    res_kind;
  logic [GRP_W-1:0]        exit_group;
  logic signed [COS_W-1:0] cosine;

  // The controller accepts an item only when idle and holds the result
  // valid until the sink takes it.
  isc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .in_cmd_i  (in_cmd),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  // The datapath performs table writes at acceptance and walks the tables
  // entry by entry for sample items.
  isc_datapath #(
    .NUM_GROUPS (NUM_GROUPS),
    .MAX_ANGLES (MAX_ANGLES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .in_cmd_i     (in_cmd),
    .from_i       (s_axis_tdata[IN_FROM_LSB +: GRP_W]),
    .to_i         (s_axis_tdata[IN_TO_LSB +: GRP_W]),
    .slot_i       (s_axis_tdata[IN_SLOT_LSB +: SLOT_W]),
    .cdf_i        (s_axis_tdata[IN_CDF_LSB +: CDF_W]),
    .cos_i        ($signed(s_axis_tdata[IN_COS_LSB +: COS_W])),
    .cnt_i        (s_axis_tdata[IN_CNT_LSB +: CNTIN_W]),
    .frac_i       (s_axis_tdata[IN_FRAC_LSB +: FRAC_W]),
    .iso_i        (s_axis_tdata[IN_ISO_BIT]),
    .res_kind_o   (res_kind),
    .exit_group_o (exit_group),
    .cosine_o     (cosine)
  );

  // Pack the result item; the padding bits are always zero.
  assign m_axis_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, cosine, exit_group};
  assign m_axis_tuser = res_kind;

endmodule

// ===== rtl/isc_port_check.sv =====
// ----------------------------------------------------------------------------
// Inverse-CDF scatter sampler port checks
// Concurrent assertions on the top-level ports, attached by a bind.
// ----------------------------------------------------------------------------
module isc_port_check import isc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [CMD_W-1:0]      s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A group result carries a zero cosine.
  a_group_cos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_COS_LSB +: COS_W] == '0)
    else $error("group result with nonzero cosine");

  // An angle result stays within [-1, 1] and carries exit group zero.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      $signed(m_axis_tdata[OUT_COS_LSB +: COS_W]) <= 32768 &&
      $signed(m_axis_tdata[OUT_COS_LSB +: COS_W]) >= -32768 &&
      m_axis_tdata[OUT_GRP_LSB +: GRP_W] == '0)
    else $error("angle result out of range");

  // A write item never raises a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
      (s_axis_tuser == CMD_WR_GROUP || s_axis_tuser == CMD_WR_ANGLE ||
       s_axis_tuser == CMD_WR_COUNT) |=> !m_axis_tvalid)
    else $error("write item produced a result");

endmodule

bind inverse_cdf_scatter_sampler isc_port_check u_port_check (.*);
